// ===== rtl/cs_pkg.sv =====
package cs_pkg;

    localparam int ELEMENT_BITS  = 16;
    localparam int FRAC_BITS     = ELEMENT_BITS - 1;
    localparam int PROD_BITS     = 2 * ELEMENT_BITS;
    localparam int DOT_BITS      = 44;
    localparam int NORM_BITS     = 43;
    localparam int LIMB_BITS     = 22;
    localparam int OPND_BITS     = 2 * LIMB_BITS;
    localparam int WIDE_BITS     = 2 * OPND_BITS;
    localparam int CMP_BITS      = WIDE_BITS + 2 * FRAC_BITS;
    localparam int MUL_STEPS     = 8;
    localparam int MUL_STEP_BITS = $clog2(MUL_STEPS);
    localparam int BIT_IDX_BITS  = $clog2(FRAC_BITS);

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] element_a;
        logic signed [ELEMENT_BITS-1:0] element_b;
        logic                           last_pair;
    } pair_t;

    typedef struct packed {
        logic signed [ELEMENT_BITS-1:0] similarity;
        logic                           zero_norm;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_MUL,
        ST_INIT,
        ST_TRY,
        ST_CMP,
        ST_DONE
    } cs_state_t;

    typedef struct packed {
        logic                     accum;
        logic                     clear;
        logic                     check;
        logic                     mul;
        logic [MUL_STEP_BITS-1:0] mul_step;
        logic                     init;
        logic                     trial;
        logic                     compare;
        logic [BIT_IDX_BITS-1:0]  bit_idx;
        logic                     load;
    } cs_cmd_t;

    typedef struct packed {
        logic norm_zero;
    } cs_stat_t;

endpackage

// ===== rtl/cs_ctrl.sv =====
module cs_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pair_valid,
    input  logic            pair_last,
    output logic            pair_stall,
    output logic            result_valid,
    input  logic            result_stall,
    input  cs_pkg::cs_stat_t stat,
    output cs_pkg::cs_cmd_t  cmd
);
    import cs_pkg::*;

    cs_state_t                state_reg, state_next;
    logic [MUL_STEP_BITS-1:0] step_reg, step_next;
    logic [BIT_IDX_BITS-1:0]  bit_reg, bit_next;
    logic                     result_valid_reg, result_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            step_reg         <= '0;
            bit_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            bit_reg          <= bit_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        bit_next     = bit_reg;
        cmd          = '0;
        cmd.mul_step = step_reg;
        cmd.bit_idx  = bit_reg;
        pair_stall   = 1'b1;

        case (state_reg)
            ST_IDLE:
            begin
                pair_stall = 1'b0;
                if (pair_valid)
                begin
                    cmd.accum = 1'b1;
                    if (pair_last)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                step_next = '0;
                state_next = stat.norm_zero ? ST_DONE : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul   = 1'b1;
                step_next = step_reg + 1'b1;
                if (step_reg == MUL_STEP_BITS'(MUL_STEPS - 1))
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                cmd.init   = 1'b1;
                bit_next   = BIT_IDX_BITS'(FRAC_BITS - 1);
                state_next = ST_TRY;
            end
            ST_TRY:
            begin
                cmd.trial  = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                cmd.compare = 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next   = bit_reg - 1'b1;
                    state_next = ST_TRY;
                end
            end
            ST_DONE:
            begin
                // The result register must be empty or emptying this cycle.
                if (!result_valid_reg || !result_stall)
                begin
                    cmd.load   = 1'b1;
                    cmd.clear  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        if (cmd.load)
        begin
            result_valid_next = 1'b1;
        end
    end

    assign result_valid = result_valid_reg;

endmodule

// ===== rtl/cs_datapath.sv =====
module cs_datapath (
    input  logic             clk,
    input  logic             rst_n,
    input  cs_pkg::pair_t    pair,
    input  cs_pkg::cs_cmd_t  cmd,
    output cs_pkg::cs_stat_t stat,
    output cs_pkg::result_t  result
);
    import cs_pkg::*;

    logic [DOT_BITS-1:0]  dot_reg, dot_next;
    logic [NORM_BITS-1:0] norm_a_reg, norm_a_next;
    logic [NORM_BITS-1:0] norm_b_reg, norm_b_next;

    logic [PROD_BITS-1:0] a_ext, b_ext;
    logic [PROD_BITS-1:0] prod_ab, prod_aa, prod_bb;
    logic [DOT_BITS:0]    dot_wide;
    logic [NORM_BITS:0]   norm_a_wide, norm_b_wide;

    logic [OPND_BITS-1:0] mag;
    logic [OPND_BITS-1:0] x_opnd, y_opnd;
    logic [LIMB_BITS-1:0] x_limb, y_limb;
    logic [OPND_BITS-1:0] partial;
    logic [1:0]           limb_pos;
    logic [WIDE_BITS-1:0] partial_shifted;

    logic [WIDE_BITS-1:0]    den_reg, rhs_reg;
    logic [CMP_BITS-1:0]     s_reg, pb_reg, d2_reg, trial_reg;
    logic [CMP_BITS-1:0]     cmp_rhs;
    logic [FRAC_BITS-1:0]    q_reg;
    logic                    zero_reg;
    logic [ELEMENT_BITS-1:0] q_ext;
    result_t                 result_reg;

    // Element products and saturating accumulation.
    always_comb
    begin
        a_ext   = {{(PROD_BITS - ELEMENT_BITS){pair.element_a[ELEMENT_BITS-1]}},
                   pair.element_a};
        b_ext   = {{(PROD_BITS - ELEMENT_BITS){pair.element_b[ELEMENT_BITS-1]}},
                   pair.element_b};
        prod_ab = a_ext * b_ext;
        prod_aa = a_ext * a_ext;
        prod_bb = b_ext * b_ext;

        dot_wide = {dot_reg[DOT_BITS-1], dot_reg}
                 + {{(DOT_BITS + 1 - PROD_BITS){prod_ab[PROD_BITS-1]}}, prod_ab};
        if (dot_wide[DOT_BITS] != dot_wide[DOT_BITS-1])
        begin
            dot_next = dot_wide[DOT_BITS] ? {1'b1, {(DOT_BITS-1){1'b0}}}
                                          : {1'b0, {(DOT_BITS-1){1'b1}}};
        end
        else
        begin
            dot_next = dot_wide[DOT_BITS-1:0];
        end

        // Squares are never negative, so only the upper bound can be crossed.
        norm_a_wide = {1'b0, norm_a_reg} + (NORM_BITS + 1)'(prod_aa);
        norm_b_wide = {1'b0, norm_b_reg} + (NORM_BITS + 1)'(prod_bb);
        norm_a_next = norm_a_wide[NORM_BITS] ? {NORM_BITS{1'b1}}
                                             : norm_a_wide[NORM_BITS-1:0];
        norm_b_next = norm_b_wide[NORM_BITS] ? {NORM_BITS{1'b1}}
                                             : norm_b_wide[NORM_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg    <= '0;
            norm_a_reg <= '0;
            norm_b_reg <= '0;
        end
        else if (cmd.clear)
        begin
            dot_reg    <= '0;
            norm_a_reg <= '0;
            norm_b_reg <= '0;
        end
        else if (cmd.accum)
        begin
            dot_reg    <= dot_next;
            norm_a_reg <= norm_a_next;
            norm_b_reg <= norm_b_next;
        end
    end

    assign stat.norm_zero = (norm_a_reg == '0) || (norm_b_reg == '0);

    // Shared limb multiplier: steps 0..3 form norm_a * norm_b, steps 4..7 form mag * mag.
    always_comb
    begin
        mag      = dot_reg[DOT_BITS-1] ? OPND_BITS'(~dot_reg + 1'b1) : OPND_BITS'(dot_reg);
        x_opnd   = cmd.mul_step[2] ? mag : OPND_BITS'(norm_a_reg);
        y_opnd   = cmd.mul_step[2] ? mag : OPND_BITS'(norm_b_reg);
        x_limb   = cmd.mul_step[1] ? x_opnd[OPND_BITS-1:LIMB_BITS] : x_opnd[LIMB_BITS-1:0];
        y_limb   = cmd.mul_step[0] ? y_opnd[OPND_BITS-1:LIMB_BITS] : y_opnd[LIMB_BITS-1:0];
        partial  = x_limb * y_limb;
        limb_pos = {1'b0, cmd.mul_step[1]} + {1'b0, cmd.mul_step[0]};
        case (limb_pos)
            2'd0:    partial_shifted = WIDE_BITS'(partial);
            2'd1:    partial_shifted = WIDE_BITS'(partial) << LIMB_BITS;
            2'd2:    partial_shifted = WIDE_BITS'(partial) << (2 * LIMB_BITS);
            default: partial_shifted = '0;
        endcase
    end

    assign cmp_rhs = {rhs_reg, {(2 * FRAC_BITS){1'b0}}};

    // Bit-by-bit search for the largest q with q*q*den <= mag*mag*2^(2*FRAC_BITS).
    // s_reg holds q*q*den, pb_reg holds (q*den) shifted up by bit+1, and
    // d2_reg holds den shifted up by twice the bit under trial.
    always_ff @(posedge clk)
    begin
        if (cmd.check)
        begin
            den_reg  <= '0;
            rhs_reg  <= '0;
            q_reg    <= '0;
            zero_reg <= stat.norm_zero;
        end
        if (cmd.mul)
        begin
            if (cmd.mul_step[2])
            begin
                rhs_reg <= rhs_reg + partial_shifted;
            end
            else
            begin
                den_reg <= den_reg + partial_shifted;
            end
        end
        if (cmd.init)
        begin
            s_reg  <= '0;
            pb_reg <= '0;
            d2_reg <= CMP_BITS'(den_reg) << (2 * (FRAC_BITS - 1));
        end
        if (cmd.trial)
        begin
            trial_reg <= s_reg + pb_reg + d2_reg;
        end
        if (cmd.compare)
        begin
            d2_reg <= d2_reg >> 2;
            if (trial_reg <= cmp_rhs)
            begin
                s_reg  <= trial_reg;
                pb_reg <= (pb_reg >> 1) + d2_reg;
                q_reg  <= q_reg | (FRAC_BITS'(1) << cmd.bit_idx);
            end
            else
            begin
                pb_reg <= pb_reg >> 1;
            end
        end
        if (cmd.load)
        begin
            result_reg.similarity <= dot_reg[DOT_BITS-1] ? -q_ext : q_ext;
            result_reg.zero_norm  <= zero_reg;
        end
    end

    assign q_ext  = {1'b0, q_reg};
    assign result = result_reg;

endmodule

// ===== rtl/cosine_similarity_stream.sv =====
// Pairs that are not last are taken one per cycle, one multiply-accumulate each.
// After a last pair the input stalls through one check, eight limb multiplies,
// one setup, a trial and a compare for each of 15 quotient bits, and one load;
// a zero norm skips the multiplies and the search. The result register then holds it,
// and a result still waiting there lengthens the stall until it is transferred.
// Reset clears the accumulators, the controller state and the result valid flag.
module cosine_similarity_stream (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pair_valid,
    output logic            pair_stall,
    input  cs_pkg::pair_t   pair,
    output logic            result_valid,
    input  logic            result_stall,
    output cs_pkg::result_t result
);
    import cs_pkg::*;

    cs_cmd_t  cmd;
    cs_stat_t stat;

    cs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pair_valid   (pair_valid),
        .pair_last    (pair.last_pair),
        .pair_stall   (pair_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .stat         (stat),
        .cmd          (cmd)
    );

    cs_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .pair   (pair),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

endmodule
